// ===== hw/rtl/esd_pkg.sv =====
// Shared types, character codes and the hex digit helper for the escape decoder.
`timescale 1ns / 1ps
`default_nettype none
package esd_pkg;

	// Decoder phase
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ESC   = 2'd1,
		PH_HEX   = 2'd2,
		PH_AFTER = 2'd3
	} phase_t;

	// Result kind
	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_OK   = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	localparam int unsigned CH_W = 21;
	localparam int unsigned CP_W = 32;

	// Input characters of interest
	localparam logic [CH_W-1:0] CH_BSLASH = 21'h00005C;
	localparam logic [CH_W-1:0] CH_QUOTE  = 21'h000022;
	localparam logic [CH_W-1:0] CH_APOS   = 21'h000027;
	localparam logic [CH_W-1:0] CH_UP_U   = 21'h000055;
	localparam logic [CH_W-1:0] CH_LO_U   = 21'h000075;
	localparam logic [CH_W-1:0] CH_LO_X   = 21'h000078;
	localparam logic [CH_W-1:0] CH_LO_N   = 21'h00006E;
	localparam logic [CH_W-1:0] CH_LO_R   = 21'h000072;
	localparam logic [CH_W-1:0] CH_LO_T   = 21'h000074;
	localparam logic [CH_W-1:0] CH_DIG_0  = 21'h000030;
	localparam logic [CH_W-1:0] CH_DIG_9  = 21'h000039;
	localparam logic [CH_W-1:0] CH_UP_A   = 21'h000041;
	localparam logic [CH_W-1:0] CH_UP_F   = 21'h000046;

	// Decoded values of the simple escapes
	localparam logic [CP_W-1:0] CP_LF     = 32'd10;
	localparam logic [CP_W-1:0] CP_CR     = 32'd13;
	localparam logic [CP_W-1:0] CP_TAB    = 32'd9;
	localparam logic [CP_W-1:0] CP_QUOTE  = 32'h22;
	localparam logic [CP_W-1:0] CP_APOS   = 32'h27;
	localparam logic [CP_W-1:0] CP_BSLASH = 32'h5C;

	// Digit counts of the hex escapes
	localparam logic [3:0] DIGITS_U8 = 4'd8;
	localparam logic [3:0] DIGITS_U4 = 4'd4;
	localparam logic [3:0] DIGITS_X2 = 4'd2;

	// Architectural state of the decoder
	typedef struct packed {
		phase_t            phase;
		logic [3:0]        digits_left;
		logic [CP_W-1:0]   acc;
	} esd_state_t;

	// One result of a step
	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [CP_W-1:0]   code_point;
		logic              last;
	} esd_result_t;

	// Hex digit value; bit 4 set marks a character that is no accepted digit
	function automatic logic [4:0] hex_value(input logic [CH_W-1:0] c);
		logic [CH_W-1:0] diff;
		begin
			diff = '0;
			if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
				diff = c - CH_DIG_0;
				hex_value = {1'b0, diff[3:0]};
			end else if (c >= CH_UP_A && c <= CH_UP_F) begin
				diff = c - CH_UP_A + 21'd10;
				hex_value = {1'b0, diff[3:0]};
			end else begin
				hex_value = 5'h10;
			end
		end
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/esd_step.sv =====
// Next-state and result logic of the escape decoder for one word.
`timescale 1ns / 1ps
`default_nettype none
module esd_step
	import esd_pkg::*;
(
	input  var esd_state_t       cur,
	input  wire  [CH_W-1:0]      ch,
	input  wire                  at_end,
	output esd_state_t           nxt,
	output esd_result_t          res
);

	logic [4:0] hex_d;
	logic       is_bslash;
	logic       hex_bad;

	// Classify the incoming character
	always_comb begin
		hex_d     = at_end ? 5'h10 : hex_value(ch);
		is_bslash = !at_end && (ch == CH_BSLASH);
		hex_bad   = hex_d[4] || (cur.digits_left == 4'd0);
	end

	// Next state
	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			PH_IDLE: begin
				if (is_bslash) nxt.phase = PH_ESC;
			end
			PH_ESC: begin
				if (at_end) begin
					nxt = '{PH_IDLE, 4'd0, '0};
				end else if (ch == CH_UP_U) begin
					nxt = '{PH_HEX, DIGITS_U8, '0};
				end else if (ch == CH_LO_U) begin
					nxt = '{PH_HEX, DIGITS_U4, '0};
				end else if (ch == CH_LO_X) begin
					nxt = '{PH_HEX, DIGITS_X2, '0};
				end else if (ch == CH_LO_N || ch == CH_LO_R || ch == CH_LO_T ||
				             ch == CH_APOS || ch == CH_QUOTE || ch == CH_BSLASH) begin
					nxt.phase = PH_AFTER;
				end else begin
					nxt = '{PH_IDLE, 4'd0, '0};
				end
			end
			PH_HEX: begin
				if (hex_bad) begin
					nxt = '{PH_IDLE, 4'd0, '0};
				end else if (cur.digits_left == 4'd1) begin
					nxt = '{PH_AFTER, 4'd0, '0};
				end else begin
					nxt.digits_left = cur.digits_left - 4'd1;
					nxt.acc         = {cur.acc[CP_W-5:0], hex_d[3:0]};
				end
			end
			PH_AFTER: begin
				if (is_bslash) nxt.phase = PH_ESC;
				else           nxt = '{PH_IDLE, 4'd0, '0};
			end
			default: nxt = '{PH_IDLE, 4'd0, '0};
		endcase
	end

	// Result
	always_comb begin
		res = '{1'b0, KIND_CHAR, '0, 1'b0};
		unique case (cur.phase)
			PH_IDLE: begin
				res.valid = 1'b0;
			end
			PH_ESC: begin
				res.valid = 1'b1;
				if (at_end) begin
					res.kind = KIND_ERR;
					res.last = 1'b1;
				end else if (ch == CH_UP_U || ch == CH_LO_U || ch == CH_LO_X) begin
					res.valid = 1'b0;
				end else if (ch == CH_LO_N) begin
					res.code_point = CP_LF;
				end else if (ch == CH_LO_R) begin
					res.code_point = CP_CR;
				end else if (ch == CH_LO_T) begin
					res.code_point = CP_TAB;
				end else if (ch == CH_APOS) begin
					res.code_point = CP_APOS;
				end else if (ch == CH_QUOTE) begin
					res.code_point = CP_QUOTE;
				end else if (ch == CH_BSLASH) begin
					res.code_point = CP_BSLASH;
				end else begin
					res.kind = KIND_ERR;
					res.last = 1'b1;
				end
			end
			PH_HEX: begin
				if (hex_bad) begin
					res.valid = 1'b1;
					res.kind  = KIND_ERR;
					res.last  = 1'b1;
				end else if (cur.digits_left == 4'd1) begin
					res.valid      = 1'b1;
					res.code_point = {cur.acc[CP_W-5:0], hex_d[3:0]};
				end
			end
			PH_AFTER: begin
				if (!is_bslash) begin
					res.valid = 1'b1;
					res.kind  = KIND_OK;
					res.last  = 1'b1;
				end
			end
			default: res.valid = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/escape_sequence_decoder.sv =====
// Top level of the backslash escape decoder: input stage, state and result register.
//
// Input stream s_axis: one code point per word; tdata carries ch, tuser flags end
// of input (ch is then ignored). Output stream m_axis: tdata the decoded code point
// (zero unless the kind is a character), tuser the kind (character, run ended,
// run ended with error), tlast marks the result that ends a run.
// A word gives at most one result; words that give none only move the state.
// Timing: an accepted word is held in the input register, passes through the step
// logic and loads the result register, which drives m_axis_tvalid. Throughput: one
// word per cycle while the receiver takes results, set by the single pass through the
// step logic between the input register and the result register.
// Reset clears both valid flags and returns the decoder to idle, waiting for a
// backslash. When the receiver stalls, the result register holds its word, the
// input register keeps the next word, and s_axis_tready falls once both are full;
// taking a result lets a new word in during the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module escape_sequence_decoder
	import esd_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,   // [20:0] ch, [23:21] zero
	input  wire         s_axis_tuser,   // [0] at_end
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] code_point
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast    // last
);

	logic            valid_s1;
	logic [CH_W-1:0] ch_s1;
	logic            at_end_s1;
	esd_state_t      state_q;
	esd_state_t      state_nxt;
	esd_result_t     res;
	logic            out_valid_q;
	kind_t           out_kind_q;
	logic [CP_W-1:0] out_cp_q;
	logic            out_last_q;
	logic            advance;

	// Stage 1 moves on when the result slot is free or being emptied
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Hold the accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1     <= s_axis_tdata[CH_W-1:0];
			at_end_s1 <= s_axis_tuser;
		end
	end

	esd_step u_step (
		.cur    (state_q),
		.ch     (ch_s1),
		.at_end (at_end_s1),
		.nxt    (state_nxt),
		.res    (res)
	);

	// Advance the decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{PH_IDLE, 4'd0, '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_kind_q <= res.kind;
			out_cp_q   <= res.code_point;
			out_last_q <= res.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_cp_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	// Checks on the decoder's own state and results
	a_hex_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_HEX |-> state_q.digits_left != 4'd0)
		else $error("hex phase with no digits left");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_IDLE |-> (state_q.digits_left == 4'd0 && state_q.acc == '0))
		else $error("idle phase with stale digit state");

	a_last_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_CHAR)))
		else $error("tlast disagrees with result kind");

	a_end_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != KIND_CHAR) |-> m_axis_tdata == '0)
		else $error("run end carries a code point");

	a_no_advance_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready && valid_s1) |=> $stable(state_q))
		else $error("state moved while result slot was blocked");

endmodule
`default_nettype wire
